// ===== rtl/core/min_error_boundary_cut_assert.svh =====
// assertion shorthands for the seam cut block, sampled on clk, off during rst
`ifndef MIN_ERROR_BOUNDARY_CUT_ASSERT_SVH
`define MIN_ERROR_BOUNDARY_CUT_ASSERT_SVH

// expression holds at every edge
`define MEBC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MEBC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define MEBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mebc_pkg.sv =====
package mebc_pkg;

  localparam int DEF_MAX_ROWS     = 32;
  localparam int DEF_MAX_OVERLAP  = 16;
  localparam int DEF_MAX_CHANNELS = 4;

  localparam int NUM_CH  = 4;
  localparam int CH_W    = 8;
  localparam int COST_W  = 26;
  localparam int PCOST_W = 18;

  localparam int ROWS_CFG_W = 6;
  localparam int OV_CFG_W   = 5;
  localparam int CH_CFG_W   = 3;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 6'd20;
  localparam logic [OV_CFG_W-1:0]   OV_RST   = 5'd4;
  localparam logic [CH_CFG_W-1:0]   CH_RST   = 3'd3;

  localparam int ROW_OUT_W   = 5;
  localparam int COL_OUT_W   = 5;
  localparam int IN_TDATA_W  = 2 * NUM_CH * CH_W;
  localparam int OUT_TDATA_W = 16;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS     = 2'd0,
    REG_OVERLAP  = 2'd1,
    REG_CHANNELS = 2'd2
  } cfg_reg_t;

  // step toward the chosen upper neighbor; also used to walk the fetch order
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_NONE  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WRITE,
    ST_LOOK,
    ST_EMIT
  } mebc_state_t;

endpackage

// ===== rtl/core/mebc_ram.sv =====
module mebc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mebc_pixel_cost.sv =====
module mebc_pixel_cost
  import mebc_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic [CH_CFG_W-1:0] ch_use,
  input  pix_t                ref_px,
  input  pix_t                blk_px,
  output logic [PCOST_W-1:0]  cost
);

  logic [NUM_CH-1:0][CH_W-1:0] diff;
  logic [PCOST_W-1:0]          sum;

  // stage 1: masked absolute channel differences
  always_ff @(posedge clk) begin
    if (load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (CH_CFG_W'(c) < ch_use) begin
          diff[c] <= (ref_px[c] >= blk_px[c]) ? (ref_px[c] - blk_px[c])
                                               : (blk_px[c] - ref_px[c]);
        end else begin
          diff[c] <= '0;
        end
      end
    end
  end

  // stage 2: sum of squares
  always_comb begin
    sum = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      sum = sum + PCOST_W'(diff[c] * diff[c]);
    end
  end

  always_ff @(posedge clk) begin
    cost <= sum;
  end

endmodule

// ===== rtl/core/min_error_boundary_cut.sv =====
// Minimum-error boundary cut over a horizontal overlap strip. Pixel pairs
// (reference, candidate block) arrive row-major on the s_ stream, one request
// per pixel, rows_in_use rows of overlap_width columns. Each pixel costs the
// sum of squared differences over the channels in use; a dynamic-programming
// seam adds to it the least of the three upper neighbors (leftmost on ties),
// saturating at 2^26-1. After the last pixel the block walks the seam back
// from the leftmost bottom-row minimum and sends one request per row on the
// m_ stream, bottom row first, with tlast on row zero. For each pixel the
// block takes the request, fetches up to three upper costs through the
// single read port of the cost memory and writes the new cost and step.
// Each result follows a step memory read, then is held until downstream takes
// it; no input is taken while results are going out. Registers out of range
// are saturated into their legal range; writing the rows, overlap or channels
// register restarts the strip. No clearing pass is needed after reset.
module min_error_boundary_cut
  import mebc_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_OVERLAP  = DEF_MAX_OVERLAP,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // pixel pair stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // fields low to high: ref_ch0, ref_ch1, ref_ch2, ref_ch3,
  //                     blk_ch0, blk_ch1, blk_ch2, blk_ch3
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // cut stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // fields low to high: row_index[4:0], cut_column[9:5], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // last_row
  output logic                   m_tlast
);

  `include "min_error_boundary_cut_assert.svh"

  localparam int COL_W = (MAX_OVERLAP > 1) ? $clog2(MAX_OVERLAP) : 1;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CA_W  = COL_W + 1;        // cost memory: row parity, column
  localparam int DA_W  = ROW_W + COL_W;    // step memory: row, column

  // configuration registers
  logic [ROWS_CFG_W-1:0] rows_cfg;
  logic [OV_CFG_W-1:0]   ov_cfg;
  logic [CH_CFG_W-1:0]   ch_cfg;

  // saturated sizes
  logic [ROW_W-1:0]    rows_last;
  logic [COL_W-1:0]    ov_last;
  logic [CH_CFG_W-1:0] ch_use;

  mebc_state_t state, state_next;

  // strip position of the next pixel
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt;

  // neighbor fetch and compare
  dir_t              fk;
  logic              fetch_ok;
  logic [COL_W-1:0]  fetch_col;
  logic              pend;
  dir_t              pend_tag;
  logic              have;
  logic [COST_W-1:0] best;
  dir_t              dir;

  logic [PCOST_W-1:0] pcost;
  logic [COST_W:0]    sum;
  logic [COST_W-1:0]  total;

  // bottom-row minimum, tracked as the row is written
  logic [COST_W-1:0] min_cost;
  logic [COL_W-1:0]  min_col;
  logic              new_min;

  // backtrack position
  logic [ROW_W-1:0] bt_row;
  logic [COL_W-1:0] bt_col;

  // memory ports
  logic              cost_we, cost_re;
  logic [CA_W-1:0]   cost_waddr, cost_raddr;
  logic [COST_W-1:0] cost_rdata;
  logic              dir_we, dir_re;
  logic [DA_W-1:0]   dir_waddr, dir_raddr;
  logic [1:0]        dir_rdata;

  logic s_acc, m_acc, row_end, strip_end;

  assign s_acc     = s_tvalid && s_tready;
  assign m_acc     = m_tvalid && m_tready;
  assign row_end   = (col_cnt == ov_last);
  assign strip_end = row_end && (row_cnt == rows_last);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RST;
      ov_cfg   <= OV_RST;
      ch_cfg   <= CH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:     rows_cfg <= cfg_data[ROWS_CFG_W-1:0];
        REG_OVERLAP:  ov_cfg   <= cfg_data[OV_CFG_W-1:0];
        REG_CHANNELS: ch_cfg   <= cfg_data[CH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_cfg < ROWS_CFG_W'(2)) begin
      rows_last = ROW_W'(1);
    end else if (int'(rows_cfg) > MAX_ROWS) begin
      rows_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last = ROW_W'(rows_cfg - ROWS_CFG_W'(1));
    end

    if (ov_cfg == '0) begin
      ov_last = '0;
    end else if (int'(ov_cfg) > MAX_OVERLAP) begin
      ov_last = COL_W'(MAX_OVERLAP - 1);
    end else begin
      ov_last = COL_W'(ov_cfg - OV_CFG_W'(1));
    end

    if (ch_cfg == '0) begin
      ch_use = CH_CFG_W'(1);
    end else if (int'(ch_cfg) > MAX_CHANNELS) begin
      ch_use = CH_CFG_W'(MAX_CHANNELS);
    end else begin
      ch_use = ch_cfg;
    end
  end

  // ------------------------------------------------------------ pixel cost
  mebc_pixel_cost u_cost (
    .clk    (clk),
    .load   (s_acc),
    .ch_use (ch_use),
    .ref_px (s_tdata[NUM_CH*CH_W-1:0]),
    .blk_px (s_tdata[IN_TDATA_W-1:NUM_CH*CH_W]),
    .cost   (pcost)
  );

  // -------------------------------------------------------- neighbor fetch
  // left, up, right in that order so a strict compare keeps the leftmost
  always_comb begin
    case (fk)
      DIR_LEFT:  fetch_col = col_cnt - COL_W'(1);
      DIR_RIGHT: fetch_col = col_cnt + COL_W'(1);
      default:   fetch_col = col_cnt;
    endcase
    case (fk)
      DIR_LEFT:  fetch_ok = (col_cnt != '0);
      DIR_UP:    fetch_ok = 1'b1;
      DIR_RIGHT: fetch_ok = !row_end;
      default:   fetch_ok = 1'b0;
    endcase
    // first row has no upper neighbors
    fetch_ok = fetch_ok && (state == ST_FETCH) && (row_cnt != '0);
  end

  // running cost of this pixel, saturated
  always_comb begin
    if (row_cnt == '0) begin
      sum = (COST_W+1)'(pcost);
    end else begin
      sum = {1'b0, best} + (COST_W+1)'(pcost);
    end
    total   = sum[COST_W] ? '1 : sum[COST_W-1:0];
    new_min = (col_cnt == '0) || (total < min_cost);
  end

  // ------------------------------------------------------------- memories
  // two cost rows alternate on the parity of the row counter
  assign cost_waddr = {row_cnt[0], col_cnt};
  assign cost_raddr = {~row_cnt[0], fetch_col};
  assign dir_waddr  = {row_cnt, col_cnt};
  assign dir_raddr  = {bt_row, bt_col};

  mebc_ram #(
    .WIDTH (COST_W),
    .DEPTH (2 ** CA_W)
  ) u_cost_mem (
    .clk   (clk),
    .we    (cost_we),
    .waddr (cost_waddr),
    .wdata (total),
    .re    (cost_re),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  mebc_ram #(
    .WIDTH (2),
    .DEPTH (2 ** DA_W)
  ) u_dir_mem (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_acc) state_next = ST_FETCH;
      ST_FETCH: if (fk == DIR_NONE) state_next = ST_WRITE;
      ST_WRITE: state_next = strip_end ? ST_LOOK : ST_IDLE;
      ST_LOOK:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (m_acc) state_next = (bt_row == '0) ? ST_IDLE : ST_LOOK;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_EMIT);
    cost_we  = (state == ST_WRITE);
    cost_re  = fetch_ok;
    dir_we   = (state == ST_WRITE) && (row_cnt != '0);
    dir_re   = (state == ST_LOOK) && (bt_row != '0);
  end

  assign m_tdata = OUT_TDATA_W'({COL_OUT_W'({1'b0, bt_col} + (COL_W+1)'(1)),
                                 ROW_OUT_W'(bt_row)});
  assign m_tlast = (bt_row == '0);

  // fetch walk and compare of returning costs
  always_ff @(posedge clk) begin
    if (rst) begin
      fk   <= DIR_LEFT;
      pend <= 1'b0;
      have <= 1'b0;
    end else begin
      pend     <= fetch_ok;
      pend_tag <= fk;
      if (s_acc) begin
        fk   <= DIR_LEFT;
        have <= 1'b0;
      end else if (state == ST_FETCH) begin
        case (fk)
          DIR_LEFT:  fk <= DIR_UP;
          DIR_UP:    fk <= DIR_RIGHT;
          default:   fk <= DIR_NONE;
        endcase
      end
      if (pend && (!have || (cost_rdata < best))) begin
        best <= cost_rdata;
        dir  <= pend_tag;
        have <= 1'b1;
      end
    end
  end

  // position counters, bottom-row minimum and backtrack
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else begin
      if (state == ST_WRITE) begin
        if (new_min) begin
          min_cost <= total;
          min_col  <= col_cnt;
        end
        if (row_end) begin
          col_cnt <= '0;
          row_cnt <= (row_cnt == rows_last) ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + COL_W'(1);
        end
        if (strip_end) begin
          bt_row <= rows_last;
          bt_col <= new_min ? col_cnt : min_col;
        end
      end
      if ((state == ST_EMIT) && m_acc && (bt_row != '0)) begin
        bt_row <= bt_row - ROW_W'(1);
        if ((dir_rdata == DIR_LEFT) && (bt_col != '0)) begin
          bt_col <= bt_col - COL_W'(1);
        end else if ((dir_rdata == DIR_RIGHT) && (bt_col != ov_last)) begin
          bt_col <= bt_col + COL_W'(1);
        end
      end
      // a register write restarts the strip
      if (cfg_we && ((cfg_index == REG_ROWS) || (cfg_index == REG_OVERLAP) ||
                     (cfg_index == REG_CHANNELS))) begin
        row_cnt <= '0;
        col_cnt <= '0;
      end
    end
  end

  // ----------------------------------------------------------- assertions
  `MEBC_ASSERT_ALWAYS(a_no_input_while_emit, !(s_tready && m_tvalid),
                      "pixel taken while cuts are going out")
  `MEBC_ASSERT_ALWAYS(a_pos_in_strip, (col_cnt <= ov_last) && (row_cnt <= rows_last),
                      "strip position outside configured size")
  `MEBC_ASSERT_IMPLY(a_cut_in_range, m_tvalid, bt_col <= ov_last,
                     "cut column beyond overlap width")
  `MEBC_ASSERT_IMPLY(a_last_on_row_zero, m_tvalid && m_tlast, m_tdata[ROW_OUT_W-1:0] == '0,
                     "last flag on a row other than zero")
  `MEBC_ASSERT_NEXT(a_idle_after_last, m_acc && m_tlast, s_tready,
                    "not ready for pixels after final cut")

endmodule
